// ===== src/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life generation step block: grid
// geometry, item mode codes and the sequencer states.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int GRID_MAX = 64;
  localparam int IDX_W    = $clog2(GRID_MAX);
  localparam int SIZE_W   = 7;
  localparam int SIZE_MIN = 3;

  typedef logic [GRID_MAX-1:0] row_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [SIZE_W-1:0]   size_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_GEN_LOAD,
    ST_GEN_READ,
    ST_GEN_CALC,
    ST_DONE
  } state_t;

endpackage

// ===== src/lgs_if.sv =====
// ----------------------------------------------------------------------------
// lgs channel interfaces
// Valid/ready channels for items, results and the size register write.
// ----------------------------------------------------------------------------
interface lgs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [5:0] row;
  logic [5:0] col;
  logic       cell_value;

  modport source (output valid, output mode, output row, output col,
                  output cell_value, input ready);
  modport sink   (input valid, input mode, input row, input col,
                  input cell_value, output ready);
endinterface

interface lgs_out_if;
  logic       valid;
  logic       ready;
  logic       cell_state;
  logic [1:0] done_mode;

  modport source (output valid, output cell_state, output done_mode, input ready);
  modport sink   (input valid, input cell_state, input done_mode, output ready);
endinterface

interface lgs_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] active_size;

  modport source (output valid, output active_size, input ready);
  modport sink   (input valid, input active_size, output ready);
endinterface

// ===== src/life_generation_step_top.sv =====
// ----------------------------------------------------------------------------
// life_generation_step_top
// Game of life grid (rule B3/S23, no wrap) with cell write, cell read and
// whole-generation advance, one item at a time.
// ----------------------------------------------------------------------------
//  channel | dir | transfer when   | payload
//  --------+-----+-----------------+---------------------------------------
//  in_ch   | in  | valid && ready  | mode, row, col, cell_value
//  out_ch  | out | valid && ready  | cell_state, done_mode
//  cfg_ch  | in  | valid && ready  | active_size (ready always high)
//
//  Steps: a write/read item fetches its row, then picks or patches the bit;
//  an advance item reads and rewrites the active rows in turn through the
//  single port row memory: one 64-cell row is read or written per cycle.
//  Reset: rst_n synchronous, active low; per-row valid flags make the whole
//  grid read as dead at once, so no clearing pass is needed.
//  Stalls: in_ch.ready is low while an item is in work; a result waiting on
//  out_ch holds the next finished item until the output register frees.
// ----------------------------------------------------------------------------
module life_generation_step_top (
  input logic       clk,
  input logic       rst_n,
  lgs_in_if.sink    in_ch,
  lgs_out_if.source out_ch,
  lgs_cfg_if.sink   cfg_ch
);

  // Grid storage: one word per row, one bit per column.
  lgs_pkg::row_t mem [lgs_pkg::GRID_MAX];
  lgs_pkg::row_t rdata_r;
  logic          rd_ok_r;
  logic [lgs_pkg::GRID_MAX-1:0] row_valid_r;

  logic          mem_re;
  logic          mem_we;
  lgs_pkg::idx_t mem_raddr;
  lgs_pkg::idx_t mem_waddr;
  lgs_pkg::row_t mem_wdata;

  lgs_pkg::state_t state_r, state_nxt;
  lgs_pkg::mode_t  mode_r, mode_nxt;
  lgs_pkg::idx_t   row_r, row_nxt;
  lgs_pkg::idx_t   col_r, col_nxt;
  logic            val_r, val_nxt;
  logic            cell_r, cell_nxt;
  lgs_pkg::row_t   above_r, above_nxt;
  lgs_pkg::row_t   cur_r, cur_nxt;

  lgs_pkg::size_t  active_size_r;
  lgs_pkg::size_t  size_eff;
  lgs_pkg::row_t   col_mask;
  lgs_pkg::row_t   row_data;
  lgs_pkg::row_t   gen_row;
  logic            last_row;
  logic            more_rows;
  logic            out_load;

  logic            out_valid_r;
  logic            out_cell_r;
  logic [1:0]      out_mode_r;

  // Size register; the user must write it only while idle, the block itself does not enforce this.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= lgs_pkg::size_t'(lgs_pkg::GRID_MAX);
    end else if (cfg_ch.valid) begin
      active_size_r <= cfg_ch.active_size;
    end
  end

  // Saturate the size into [3, GRID_MAX].
  always_comb begin
    if (active_size_r < lgs_pkg::size_t'(lgs_pkg::SIZE_MIN)) begin
      size_eff = lgs_pkg::size_t'(lgs_pkg::SIZE_MIN);
    end else if (active_size_r > lgs_pkg::size_t'(lgs_pkg::GRID_MAX)) begin
      size_eff = lgs_pkg::size_t'(lgs_pkg::GRID_MAX);
    end else begin
      size_eff = active_size_r;
    end
  end

  always_comb begin
    for (int c = 0; c < lgs_pkg::GRID_MAX; c++) begin
      col_mask[c] = (lgs_pkg::size_t'(c) < size_eff);
    end
  end

  assign last_row  = ({1'b0, row_r} == size_eff - lgs_pkg::size_t'(1));
  assign more_rows = ({1'b0, row_r} + lgs_pkg::size_t'(1) < size_eff);

  // Row memory: one access per cycle, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Rows never written since reset read as all dead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_ok_r     <= 1'b0;
    end else begin
      if (mem_we) begin
        row_valid_r[mem_waddr] <= 1'b1;
      end
      rd_ok_r <= mem_re && row_valid_r[mem_raddr];
    end
  end

  assign row_data = rd_ok_r ? rdata_r : '0;

  // Row update unit: all 64 lanes of one row per cycle. Above, current and
  // below rows are masked to the active columns and padded with dead cells.
  always_comb begin
    logic [lgs_pkg::GRID_MAX+1:0] pa;
    logic [lgs_pkg::GRID_MAX+1:0] pc;
    logic [lgs_pkg::GRID_MAX+1:0] pb;
    logic [3:0] cnt;
    logic       born;
    pa = {1'b0, above_r & col_mask, 1'b0};
    pc = {1'b0, cur_r & col_mask, 1'b0};
    pb = {1'b0, row_data & col_mask, 1'b0};
    for (int c = 0; c < lgs_pkg::GRID_MAX; c++) begin
      cnt = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2])
          + 4'(pc[c]) + 4'(pc[c+2])
          + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
      born = (cnt == 4'd3) || ((cnt == 4'd2) && cur_r[c]);
      // Columns outside the active square keep their stored value.
      gen_row[c] = col_mask[c] ? born : cur_r[c];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lgs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    val_r   <= val_nxt;
    cell_r  <= cell_nxt;
    above_r <= above_nxt;
    cur_r   <= cur_nxt;
  end

  assign in_ch.ready = (state_r == lgs_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    val_nxt   = val_r;
    cell_nxt  = cell_r;
    above_nxt = above_r;
    cur_nxt   = cur_r;
    mem_re    = 1'b0;
    mem_raddr = row_r;
    mem_we    = 1'b0;
    mem_waddr = row_r;
    mem_wdata = row_data;
    out_load  = 1'b0;

    case (state_r)
      lgs_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt = lgs_pkg::mode_t'(in_ch.mode);
          row_nxt  = in_ch.row;
          col_nxt  = in_ch.col;
          val_nxt  = in_ch.cell_value;
          cell_nxt = 1'b0;
          case (lgs_pkg::mode_t'(in_ch.mode))
            lgs_pkg::MODE_WRITE, lgs_pkg::MODE_READ: begin
              // Fetch the row; the bit is picked or patched next cycle.
              mem_re    = 1'b1;
              mem_raddr = in_ch.row;
              state_nxt = lgs_pkg::ST_ACCESS;
            end
            lgs_pkg::MODE_STEP: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              row_nxt   = '0;
              state_nxt = lgs_pkg::ST_GEN_LOAD;
            end
            default: begin
              state_nxt = lgs_pkg::ST_DONE;
            end
          endcase
        end
      end

      lgs_pkg::ST_ACCESS: begin
        if (mode_r == lgs_pkg::MODE_WRITE) begin
          mem_we           = 1'b1;
          mem_waddr        = row_r;
          mem_wdata        = row_data;
          mem_wdata[col_r] = val_r;
        end else begin
          cell_nxt = row_data[col_r];
        end
        state_nxt = lgs_pkg::ST_DONE;
      end

      lgs_pkg::ST_GEN_LOAD: begin
        above_nxt = '0;
        cur_nxt   = row_data;
        state_nxt = lgs_pkg::ST_GEN_READ;
      end

      lgs_pkg::ST_GEN_READ: begin
        // Fetch the row below; past the last active row it stays dead.
        mem_re    = more_rows;
        mem_raddr = row_r + lgs_pkg::idx_t'(1);
        state_nxt = lgs_pkg::ST_GEN_CALC;
      end

      lgs_pkg::ST_GEN_CALC: begin
        // Old rows are held in above/cur, so overwrite this row in place.
        mem_we    = 1'b1;
        mem_waddr = row_r;
        mem_wdata = gen_row;
        above_nxt = cur_r;
        cur_nxt   = row_data;
        if (last_row) begin
          state_nxt = lgs_pkg::ST_DONE;
        end else begin
          row_nxt   = row_r + lgs_pkg::idx_t'(1);
          state_nxt = lgs_pkg::ST_GEN_READ;
        end
      end

      lgs_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = lgs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lgs_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cell_r <= cell_r;
      out_mode_r <= mode_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_state = out_cell_r;
  assign out_ch.done_mode  = out_mode_r;

endmodule

// ===== src/lgs_checker.sv =====
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks for the life generation step block, bound to the top.
// ----------------------------------------------------------------------------
module lgs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       cell_state,
  input logic [1:0] done_mode
);

  // One item at a time: no transfer right after an accepted item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted item");

  // Only a read item reports a cell.
  a_cell_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (done_mode != lgs_pkg::MODE_READ)) |-> !cell_state)
    else $error("cell_state set on a non-read result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(cell_state) && $stable(done_mode)))
    else $error("result changed while stalled");

endmodule

bind life_generation_step_top lgs_checker u_lgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .cell_state (out_ch.cell_state),
  .done_mode  (out_ch.done_mode)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for life_generation_step_top. Items drive cell writes,
// cell reads, generation steps and the unused mode over the input channel.
// A grid model in the bench predicts each result. Results are checked in
// order against that model. The active size register is rewritten between
// phases, once the block has drained, and covers its extreme values. Both
// channels get random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_ITEMS     = 10;

  typedef struct packed {
    logic           cell_state;
    lgs_pkg::mode_t done_mode;
  } cell_result_t;

  logic clk;
  logic rst_n;

  lgs_in_if  in_if ();
  lgs_out_if out_if ();
  lgs_cfg_if cfg_if ();

  life_generation_step_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Grid model and its size register, updated at each accepted transfer.
  bit             model_grid [lgs_pkg::GRID_MAX][lgs_pkg::GRID_MAX];
  lgs_pkg::size_t model_size;

  cell_result_t pending_results [$];

  int  error_count;
  int  results_checked;
  int  cfg_writes;
  int  mode_count [4];
  int  idle_cycles;
  // Quiet phases run with no gaps on either side.
  bit  quiet_phase;
  int  out_stall_left;

  // --------------------------------------------------------------------------
  // Clock: 10 ns period.
  // --------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Grid model
  // --------------------------------------------------------------------------
  function automatic int clamped_size();
    int n;
    n = int'(model_size);
    if (n < lgs_pkg::SIZE_MIN) n = lgs_pkg::SIZE_MIN;
    if (n > lgs_pkg::GRID_MAX) n = lgs_pkg::GRID_MAX;
    return n;
  endfunction

  // Build the next generation from the current one, then replace it.
  // Neighbors outside the active square count as dead; cells outside it
  // keep their value.
  function automatic void advance_generation();
    bit next_grid [lgs_pkg::GRID_MAX][lgs_pkg::GRID_MAX];
    int n;
    int live;
    int rr;
    int cc;
    n = clamped_size();
    next_grid = model_grid;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < n && cc < n)
              live += model_grid[rr][cc];
          end
        end
        if (live == 3) next_grid[r][c] = 1'b1;
        else if (live != 2) next_grid[r][c] = 1'b0;
      end
    end
    model_grid = next_grid;
  endfunction

  // Apply one item to the model and return the result it yields.
  function automatic cell_result_t predict_item(lgs_pkg::mode_t m, lgs_pkg::idx_t r,
                                                lgs_pkg::idx_t c, logic v);
    cell_result_t res;
    res.cell_state = 1'b0;
    res.done_mode  = m;
    case (m)
      lgs_pkg::MODE_WRITE: model_grid[r][c] = v;
      lgs_pkg::MODE_STEP:  advance_generation();
      lgs_pkg::MODE_READ:  res.cell_state = model_grid[r][c];
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Gap lengths: mostly none or short, now and then a long one.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    if (quiet_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Every task starts and ends just after a falling edge, so each
  // input gets at most one nonblocking update per time step.
  // --------------------------------------------------------------------------
  task automatic send_item(lgs_pkg::mode_t m, lgs_pkg::idx_t r, lgs_pkg::idx_t c,
                           logic v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.row        <= r;
    in_if.col        <= c;
    in_if.cell_value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    // Predict at the transfer, in acceptance order.
    pending_results.push_back(predict_item(m, r, c, v));
    mode_count[m]++;
    @(negedge clk);
  endtask

  // Hold the sender until every expected result is back, then let the
  // block settle before anything touches its register.
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_active_size(lgs_pkg::size_t value);
    wait_results_drained();
    cfg_if.valid       <= 1'b1;
    cfg_if.active_size <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    model_size = value;
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls on ready, none in quiet phases.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (quiet_phase || !rst_n) begin
      out_if.ready <= 1'b1;
      out_stall_left = 0;
    end else if (out_stall_left > 0) begin
      out_if.ready <= 1'b0;
      out_stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      out_stall_left = pick_gap();
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: cell_state %0b, done_mode %0d",
               out_if.cell_state, out_if.done_mode);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_if.cell_state !== want.cell_state) begin
          $error("cell_state: expected %0b, got %0b", want.cell_state, out_if.cell_state);
          error_count++;
        end
        if (out_if.done_mode !== want.done_mode) begin
          $error("done_mode: expected %0d, got %0d", want.done_mode, out_if.done_mode);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_CYCLES);
      $display("** life_generation_step_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Write and read the corner cells of the full storage, overwrite one with
  // a dead value, read an untouched cell and send the unused mode.
  task automatic test_cell_access();
    send_item(lgs_pkg::MODE_WRITE, 6'd0,  6'd0,  1'b1);
    send_item(lgs_pkg::MODE_WRITE, 6'd63, 6'd63, 1'b1);
    send_item(lgs_pkg::MODE_WRITE, 6'd0,  6'd63, 1'b1);
    send_item(lgs_pkg::MODE_WRITE, 6'd63, 6'd0,  1'b1);
    send_item(lgs_pkg::MODE_READ,  6'd0,  6'd0,  1'b0);
    send_item(lgs_pkg::MODE_READ,  6'd63, 6'd63, 1'b1);
    send_item(lgs_pkg::MODE_READ,  6'd0,  6'd63, 1'b0);
    send_item(lgs_pkg::MODE_READ,  6'd63, 6'd0,  1'b1);
    send_item(lgs_pkg::MODE_READ,  6'd31, 6'd31, 1'b0);
    send_item(lgs_pkg::MODE_WRITE, 6'd63, 6'd63, 1'b0);
    send_item(lgs_pkg::MODE_READ,  6'd63, 6'd63, 1'b0);
    send_item(lgs_pkg::MODE_NONE,  6'd42, 6'd21, 1'b1);
  endtask

  // Blinker on the smallest grid: the edges must not wrap, and live cells
  // outside the active square must survive a step untouched.
  task automatic test_blinker_small_grid();
    write_active_size(lgs_pkg::size_t'(lgs_pkg::SIZE_MIN));
    send_item(lgs_pkg::MODE_WRITE, 6'd0, 6'd1, 1'b1);
    send_item(lgs_pkg::MODE_WRITE, 6'd1, 6'd1, 1'b1);
    send_item(lgs_pkg::MODE_WRITE, 6'd2, 6'd1, 1'b1);
    send_item(lgs_pkg::MODE_STEP,  6'd0, 6'd0, 1'b0);
    send_item(lgs_pkg::MODE_READ,  6'd1, 6'd0, 1'b0);
    send_item(lgs_pkg::MODE_READ,  6'd0, 6'd1, 1'b0);
    send_item(lgs_pkg::MODE_READ,  6'd1, 6'd2, 1'b0);
    send_item(lgs_pkg::MODE_READ,  6'd0, 6'd63, 1'b0);
    send_item(lgs_pkg::MODE_STEP,  6'd63, 6'd63, 1'b1);
    send_item(lgs_pkg::MODE_READ,  6'd0, 6'd1, 1'b0);
  endtask

  // One coordinate near an anchor, clipped to the storage.
  function automatic lgs_pkg::idx_t near_coord(int anchor);
    int v;
    v = anchor + $urandom_range(0, 2) - 1;
    if (v < 0) v = 0;
    if (v > lgs_pkg::GRID_MAX - 1) v = lgs_pkg::GRID_MAX - 1;
    return lgs_pkg::idx_t'(v);
  endfunction

  // Seed a 3x3 patch around a random anchor, step, and read the patch back.
  task automatic send_patch_burst(ref int sent);
    int n;
    int r0;
    int c0;
    int writes;
    int steps;
    int reads;
    n = clamped_size();
    r0 = $urandom_range(0, n - 1);
    c0 = $urandom_range(0, n - 1);
    writes = $urandom_range(3, 6);
    steps = $urandom_range(1, 2);
    reads = $urandom_range(3, 5);
    repeat (writes) begin
      send_item(lgs_pkg::MODE_WRITE, near_coord(r0), near_coord(c0),
                $urandom_range(0, 9) < 7);
      sent++;
    end
    repeat (steps) begin
      send_item(lgs_pkg::MODE_STEP, lgs_pkg::idx_t'($urandom), lgs_pkg::idx_t'($urandom),
                1'($urandom));
      sent++;
    end
    repeat (reads) begin
      send_item(lgs_pkg::MODE_READ, near_coord(r0), near_coord(c0), 1'($urandom));
      sent++;
    end
  endtask

  // Random phases, each under its own size setting; the extremes come first,
  // and the saturating values are mixed in among the others.
  task automatic test_random_phases();
    lgs_pkg::size_t sizes [$];
    int             sent;
    sizes = '{7'd0, 7'd127, 7'd3, 7'd64, 7'd1, 7'd5, 7'd2, 7'd8, 7'd65,
              lgs_pkg::size_t'($urandom_range(4, 16))};
    foreach (sizes[i]) begin
      write_active_size(sizes[i]);
      quiet_phase = (i % 3 == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          send_patch_burst(sent);
        end else begin
          // Noise: any mode, anywhere in the storage.
          send_item(lgs_pkg::mode_t'($urandom_range(0, 3)), lgs_pkg::idx_t'($urandom),
                    lgs_pkg::idx_t'($urandom), 1'($urandom));
          sent++;
        end
      end
      quiet_phase = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.mode         = lgs_pkg::MODE_WRITE;
    in_if.row          = '0;
    in_if.col          = '0;
    in_if.cell_value   = 1'b0;
    out_if.ready       = 1'b1;
    cfg_if.valid       = 1'b0;
    cfg_if.active_size = 7'd64;
    quiet_phase        = 1'b0;
    error_count        = 0;
    results_checked    = 0;
    cfg_writes         = 0;
    idle_cycles        = 0;
    out_stall_left     = 0;
    mode_count         = '{0, 0, 0, 0};
    model_size         = lgs_pkg::size_t'(lgs_pkg::GRID_MAX);
    foreach (model_grid[r, c]) model_grid[r][c] = 1'b0;

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_cell_access();
    test_blinker_small_grid();
    test_random_phases();

    wait_results_drained();
    repeat (20) @(negedge clk);

    $display("covered %0d writes, %0d steps, %0d reads, %0d unused-mode items",
             mode_count[lgs_pkg::MODE_WRITE], mode_count[lgs_pkg::MODE_STEP],
             mode_count[lgs_pkg::MODE_READ], mode_count[lgs_pkg::MODE_NONE]);
    $display("checked %0d results across %0d size register writes",
             results_checked, cfg_writes);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("** life_generation_step_top: PASSED **");
    end else begin
      $display("** life_generation_step_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lgs_pkg.sv
src/lgs_if.sv
src/life_generation_step_top.sv
src/lgs_checker.sv
tb/testbench.sv
